### design/tpc_pkg.sv
// Shared types, codes and constants of the trie prefix classifier.
`default_nettype none

package tpc_pkg;

  // Default node store size
  localparam int TPC_MAX_NODES = 512;

  // Field widths
  localparam int SYM_W = 7;
  localparam int KC_W  = 3;
  localparam int CAT_W = 4;
  localparam int REP_W = 2;
  localparam int POS_W = 2;

  // Operation codes
  localparam logic OP_CLASSIFY = 1'b0;
  localparam logic OP_INSERT   = 1'b1;

  // Report codes
  localparam logic [REP_W-1:0] REP_CLASSIFY       = 2'd0;
  localparam logic [REP_W-1:0] REP_INSERT_DONE    = 2'd1;
  localparam logic [REP_W-1:0] REP_INSERT_REFUSED = 2'd2;

  // Category codes
  localparam logic [CAT_W-1:0] CAT_SALU    = 4'd2;
  localparam logic [CAT_W-1:0] CAT_VALU    = 4'd8;
  localparam logic [CAT_W-1:0] CAT_UNKNOWN = 4'd9;
  localparam logic [CAT_W-1:0] KIND_NONE   = 4'd15;

  // Characters that form the special prefixes
  localparam logic [SYM_W-1:0] CHR_V     = 7'h76;
  localparam logic [SYM_W-1:0] CHR_S     = 7'h73;
  localparam logic [SYM_W-1:0] CHR_UNDER = 7'h5f;

  // Position in the mnemonic being walked
  localparam logic [POS_W-1:0] POS_FIRST    = 2'd0;
  localparam logic [POS_W-1:0] POS_SECOND   = 2'd1;
  localparam logic [POS_W-1:0] POS_S_PREFIX = 2'd2;
  localparam logic [POS_W-1:0] POS_OTHER    = 2'd3;

  // Sequencer states
  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EDGE  = 5'b00100,
    S_KIND  = 5'b01000,
    S_HOLD  = 5'b10000
  } tpc_state_t;

endpackage

`default_nettype wire

### design/tpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                      clk,
  input  wire logic                                      wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                          wr_data,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### design/trie_prefix_classifier.sv
// Top level: character trie that builds a dictionary and classifies mnemonics.
// A result word is registered into the output from the S_EDGE state, or from the S_KIND
// state for a classify word that follows an edge; a busy output holds it in S_HOLD.
// Words are taken one at a time: in_tready is high only in S_IDLE, so a new word waits for
// the edge memory read, the node-kind memory read of a child node and any stalled result.
// Reset: synchronous, active low; afterwards the edge memory is cleared one entry
// per cycle, all MAX_NODES*128 entries, while in_tready stays low.
`default_nettype none

module trie_prefix_classifier #(
  parameter int MAX_NODES = tpc_pkg::TPC_MAX_NODES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: symbol [6:0], key_category [9:7], zero [15:10]
  input  wire logic [15:0] in_tdata,
  // in_tuser: operation [0]
  input  wire logic [0:0]  in_tuser,
  input  wire logic        in_tlast,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: category [3:0], zero [7:4]
  output logic      [7:0]  out_tdata,
  // out_tuser: report [1:0]
  output logic      [1:0]  out_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready
);

  import tpc_pkg::*;

  localparam int NODE_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int EDGE_AW    = NODE_W + SYM_W;
  localparam int EDGE_DEPTH = MAX_NODES * (1 << SYM_W);
  localparam int CNT_W      = $clog2(MAX_NODES + 1);

  tpc_state_t state_r, state_nxt;

  logic [EDGE_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0]   nodes_used_r, nodes_used_nxt;
  logic [NODE_W-1:0]  walk_node_r, walk_node_nxt;
  logic [CAT_W-1:0]   walk_kind_r, walk_kind_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [SYM_W-1:0]   first_sym_r, first_sym_nxt;
  logic               decided_r, decided_nxt;
  logic [NODE_W-1:0]  ins_cur_r, ins_cur_nxt;
  logic               ins_ref_r, ins_ref_nxt;

  // Accepted word
  logic               op_r;
  logic [SYM_W-1:0]   sym_r;
  logic               last_r;
  logic [KC_W-1:0]    kc_r;

  // Output register and hold stage
  logic               out_valid_r, out_valid_nxt;
  logic [REP_W-1:0]   out_rep_r, out_rep_nxt;
  logic [CAT_W-1:0]   out_cat_r, out_cat_nxt;
  logic [REP_W-1:0]   hold_rep_r, hold_rep_nxt;
  logic [CAT_W-1:0]   hold_cat_r, hold_cat_nxt;

  // Memory ports
  logic               edge_we;
  logic [EDGE_AW-1:0] edge_waddr, edge_raddr;
  logic [NODE_W-1:0]  edge_wdata, edge_rdata;
  logic               kind_we;
  logic [NODE_W-1:0]  kind_waddr;
  logic [CAT_W-1:0]   kind_wdata, kind_rdata;

  logic               in_fire;
  logic               out_free;
  logic               v_prefix;
  logic               adv_need;
  logic [CAT_W-1:0]   k_sel;
  logic [CAT_W-1:0]   found;
  logic [POS_W-1:0]   pos_new;
  logic               res_valid;
  logic [REP_W-1:0]   res_rep;
  logic [CAT_W-1:0]   res_cat;
  logic               store_full;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_cat_r};
  assign out_tuser  = out_rep_r;

  assign v_prefix   = (first_sym_r == CHR_V) && (sym_r == CHR_UNDER);
  assign adv_need   = (pos_r != POS_SECOND) || (!v_prefix && (walk_kind_r == KIND_NONE));
  assign k_sel      = (state_r == S_KIND) ? kind_rdata : walk_kind_r;
  assign store_full = (nodes_used_r == CNT_W'(MAX_NODES));

  // Read the edge of the matching cursor as the word is accepted
  assign edge_raddr = {((in_tuser[0] == OP_INSERT) ? ins_cur_r : walk_node_r),
                       in_tdata[SYM_W-1:0]};

  tpc_ram #(
    .WIDTH (NODE_W),
    .DEPTH (EDGE_DEPTH)
  ) u_edge_ram (
    .clk     (clk),
    .wr_en   (edge_we),
    .wr_addr (edge_waddr),
    .wr_data (edge_wdata),
    .rd_addr (edge_raddr),
    .rd_data (edge_rdata)
  );

  tpc_ram #(
    .WIDTH (CAT_W),
    .DEPTH (MAX_NODES)
  ) u_kind_ram (
    .clk     (clk),
    .wr_en   (kind_we),
    .wr_addr (kind_waddr),
    .wr_data (kind_wdata),
    .rd_addr (edge_rdata),
    .rd_data (kind_rdata)
  );

  // Classification decision for the current character, given the walk node kind
  always_comb begin
    found   = KIND_NONE;
    pos_new = pos_r;
    case (pos_r)
      POS_FIRST: begin
        if ((k_sel != KIND_NONE) && !((sym_r == CHR_V) && !last_r)) begin
          found = k_sel;
        end
        pos_new = POS_SECOND;
      end
      POS_SECOND: begin
        if (v_prefix) begin
          found = CAT_VALU;
        end else begin
          found = k_sel;
        end
        pos_new = ((first_sym_r == CHR_S) && (sym_r == CHR_UNDER)) ? POS_S_PREFIX : POS_OTHER;
      end
      default: begin
        found = k_sel;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    nodes_used_nxt = nodes_used_r;
    walk_node_nxt  = walk_node_r;
    walk_kind_nxt  = walk_kind_r;
    pos_nxt        = pos_r;
    first_sym_nxt  = first_sym_r;
    decided_nxt    = decided_r;
    ins_cur_nxt    = ins_cur_r;
    ins_ref_nxt    = ins_ref_r;
    hold_rep_nxt   = hold_rep_r;
    hold_cat_nxt   = hold_cat_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_rep_nxt    = out_rep_r;
    out_cat_nxt    = out_cat_r;
    edge_we        = 1'b0;
    edge_waddr     = {ins_cur_r, sym_r};
    edge_wdata     = nodes_used_r[NODE_W-1:0];
    kind_we        = 1'b0;
    kind_waddr     = nodes_used_r[NODE_W-1:0];
    kind_wdata     = KIND_NONE;
    res_valid      = 1'b0;
    res_rep        = REP_CLASSIFY;
    res_cat        = '0;

    case (state_r)
      S_CLEAR: begin
        // Sweep the edge memory to no child
        edge_we      = 1'b1;
        edge_waddr   = clr_addr_r;
        edge_wdata   = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == EDGE_AW'(EDGE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EDGE;
        end
      end

      S_EDGE: begin
        state_nxt = S_IDLE;
        if (op_r == OP_INSERT) begin
          // Follow or allocate the edge for this key character
          if (!ins_ref_r) begin
            if (edge_rdata == '0) begin
              if (!store_full) begin
                edge_we        = 1'b1;
                kind_we        = 1'b1;
                kind_waddr     = nodes_used_r[NODE_W-1:0];
                kind_wdata     = last_r ? {1'b0, kc_r} : KIND_NONE;
                ins_cur_nxt    = nodes_used_r[NODE_W-1:0];
                nodes_used_nxt = nodes_used_r + 1'b1;
              end else begin
                ins_ref_nxt = 1'b1;
              end
            end else begin
              ins_cur_nxt = edge_rdata;
              if (last_r) begin
                kind_we    = 1'b1;
                kind_waddr = edge_rdata;
                kind_wdata = {1'b0, kc_r};
              end
            end
          end
          if (last_r) begin
            res_valid   = 1'b1;
            res_rep     = (ins_ref_r || (edge_rdata == '0 && store_full)) ?
                          REP_INSERT_REFUSED : REP_INSERT_DONE;
            res_cat     = '0;
            ins_cur_nxt = '0;
            ins_ref_nxt = 1'b0;
          end
        end else if (decided_r) begin
          // Skip the rest of a decided mnemonic
          if (last_r) begin
            walk_node_nxt = '0;
            walk_kind_nxt = KIND_NONE;
            pos_nxt       = POS_FIRST;
            first_sym_nxt = '0;
            decided_nxt   = 1'b0;
          end
        end else if (adv_need && (edge_rdata != '0)) begin
          // Move to the child and fetch its kind
          walk_node_nxt = edge_rdata;
          state_nxt     = S_KIND;
        end else begin
          res_valid = 1'b1;
        end
      end

      S_KIND: begin
        state_nxt = S_IDLE;
        res_valid = 1'b1;
      end

      S_HOLD: begin
        // Move the held result into the output register
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rep_nxt   = hold_rep_r;
          out_cat_nxt   = hold_cat_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Forward a category written into the node the walk stands on
    if (kind_we && (kind_waddr == walk_node_r)) begin
      walk_kind_nxt = kind_wdata;
    end

    // Finish a classify character
    if (res_valid && (op_r == OP_CLASSIFY)) begin
      walk_kind_nxt = k_sel;
      pos_nxt       = pos_new;
      if (pos_r == POS_FIRST) begin
        first_sym_nxt = sym_r;
      end
      res_rep   = REP_CLASSIFY;
      res_cat   = (found != KIND_NONE) ? found :
                  ((pos_new == POS_S_PREFIX) ? CAT_SALU : CAT_UNKNOWN);
      res_valid = (found != KIND_NONE) || last_r;
      if (res_valid) begin
        if (last_r) begin
          walk_node_nxt = '0;
          walk_kind_nxt = KIND_NONE;
          pos_nxt       = POS_FIRST;
          first_sym_nxt = '0;
          decided_nxt   = 1'b0;
        end else begin
          decided_nxt = 1'b1;
        end
      end
    end

    // Deliver a result, or hold it while the output is busy
    if (res_valid) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_rep_nxt   = res_rep;
        out_cat_nxt   = res_cat;
      end else begin
        hold_rep_nxt = res_rep;
        hold_cat_nxt = res_cat;
        state_nxt    = S_HOLD;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      nodes_used_r <= CNT_W'(1);
      walk_node_r  <= '0;
      walk_kind_r  <= KIND_NONE;
      pos_r        <= POS_FIRST;
      first_sym_r  <= '0;
      decided_r    <= 1'b0;
      ins_cur_r    <= '0;
      ins_ref_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      nodes_used_r <= nodes_used_nxt;
      walk_node_r  <= walk_node_nxt;
      walk_kind_r  <= walk_kind_nxt;
      pos_r        <= pos_nxt;
      first_sym_r  <= first_sym_nxt;
      decided_r    <= decided_nxt;
      ins_cur_r    <= ins_cur_nxt;
      ins_ref_r    <= ins_ref_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_tuser[0];
      sym_r  <= in_tdata[SYM_W-1:0];
      last_r <= in_tlast;
      kc_r   <= in_tdata[SYM_W+KC_W-1:SYM_W];
    end
    out_rep_r  <= out_rep_nxt;
    out_cat_r  <= out_cat_nxt;
    hold_rep_r <= hold_rep_nxt;
    hold_cat_r <= hold_cat_nxt;
  end

endmodule

`default_nettype wire

### design/tpc_checker.sv
// Port-level checks of the trie prefix classifier and their bind.
`default_nettype none

module tpc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready
);

  import tpc_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // Reset empties the output and starts the clearing sweep
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("block not quiet after reset");

  // Only the three defined reports appear
  a_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == REP_CLASSIFY) || (out_tuser == REP_INSERT_DONE) ||
                   (out_tuser == REP_INSERT_REFUSED))
    else $error("undefined report code");

  // Insert reports carry a zero category
  a_ins_cat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != REP_CLASSIFY) |-> out_tdata == 8'd0)
    else $error("insert report with a nonzero category");

  // A word accepted is followed by a low in_tready in the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted while the first is at work");

endmodule

bind trie_prefix_classifier tpc_checker u_tpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire
